[hdl/cso_pkg.sv]
// Shared constants and types for the source-over tile compositor.
// Depends on nothing; every design file of the block imports it (the checker does not).
`default_nettype none

package cso_pkg;

	// Tile geometry. The accumulator store holds one entry per pixel.
	localparam int unsigned TILE_SIDE = 256;
	localparam int unsigned PIXELS    = TILE_SIDE * TILE_SIDE;
	localparam int unsigned ADDR_W    = $clog2(PIXELS);

	// Field widths.
	localparam int unsigned IDX_W       = 16;
	localparam int unsigned CH_W        = 8;
	localparam int unsigned LANE_W      = 16;
	localparam int unsigned NUM_LANES   = 4;
	localparam int unsigned NUM_COLOURS = 3;
	localparam int unsigned ALPHA_LANE  = 3;

	// Fixed-point unit: 65025 stands for 1.0, and half of it for rounding.
	localparam int unsigned UNIT       = 65025;
	localparam int unsigned ROUND_HALF = 32512;

	typedef logic [CH_W-1:0]   channel_t;
	typedef logic [LANE_W-1:0] lane_t;
	// Lane 0 red, 1 green, 2 blue, 3 alpha (bits 63:48).
	typedef lane_t [NUM_LANES-1:0] accum_t;

	typedef enum logic {
		OP_BLEND   = 1'b0,
		OP_RESOLVE = 1'b1
	} op_t;

endpackage

`default_nettype wire

[hdl/cso_store.sv]
// Per-pixel accumulator memory: one write port and one read port with registered data.
// Depends on cso_pkg for the depth, address width and entry type.
`default_nettype none

module cso_store import cso_pkg::*; (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire accum_t            wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output accum_t                 rd_data
);

	accum_t mem [PIXELS];
	accum_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hdl/cso_blend.sv]
// Source-over blend datapath: four lanes, five pipeline stages, result divided by 65025.
// Depends on cso_pkg for the accumulator type and fixed-point constants.
`default_nettype none

module cso_blend import cso_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [LANE_W-1:0]           sa,
	input  wire logic [LANE_W-1:0]           inv,
	input  wire channel_t [NUM_COLOURS-1:0] colour,
	input  wire accum_t                      word,
	output logic                             done,
	output accum_t                           result
);

	localparam int unsigned SRC_W  = CH_W + LANE_W;          // c * sa
	localparam int unsigned DST_W  = 2 * LANE_W;             // d * inv
	localparam int unsigned NUM_W  = 2 * LANE_W + 1;         // whole numerator
	localparam int unsigned HI_W   = NUM_W - CH_W;           // numerator without low byte
	localparam int unsigned RCP_W  = 25;
	localparam int unsigned PROD_W = HI_W + RCP_W;
	localparam int unsigned QUO_W  = PROD_W - 32;
	localparam int unsigned REM_W  = LANE_W + 1;
	localparam int unsigned WIDE_W = NUM_W + 1;
	// floor(2^40 / 65025): the estimate is never high and at most one low.
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << 40) / 64'(UNIT));

	logic [NUM_LANES-1:0][CH_W-1:0]   mulc;
	logic [NUM_LANES-1:0][SRC_W-1:0]  src_s1;
	logic [NUM_LANES-1:0][DST_W-1:0]  dst_s1;
	logic [NUM_LANES-1:0][NUM_W-1:0]  num_s2, num_s3;
	logic [NUM_LANES-1:0][QUO_W-1:0]  q0_s3, q0_s4;
	logic [NUM_LANES-1:0][REM_W-1:0]  rem_s4;
	logic [NUM_LANES-1:0][PROD_W-1:0] est;
	logic [NUM_LANES-1:0][QUO_W-1:0]  qfix;
	accum_t                           res_s5;
	logic [4:0]                       vld_q;

	// The alpha lane uses 255 as its colour so that its source term is sa * 65025.
	always_comb begin
		for (int k = 0; k < NUM_COLOURS; k++) begin
			mulc[k] = colour[k];
		end
		mulc[ALPHA_LANE] = '1;
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			est[k]  = PROD_W'(num_s2[k][NUM_W-1:CH_W]) * PROD_W'(RECIP);
			qfix[k] = q0_s4[k] + QUO_W'(rem_s4[k] >= REM_W'(UNIT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], start};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_LANES; k++) begin
			src_s1[k] <= SRC_W'(mulc[k]) * SRC_W'(sa);
			dst_s1[k] <= DST_W'(word[k]) * DST_W'(inv);
			num_s2[k] <= NUM_W'({src_s1[k], CH_W'(0)}) - NUM_W'(src_s1[k])
				+ NUM_W'(dst_s1[k]) + NUM_W'(ROUND_HALF);
			num_s3[k] <= num_s2[k];
			q0_s3[k]  <= est[k][PROD_W-1:32];
			q0_s4[k]  <= q0_s3[k];
			rem_s4[k] <= REM_W'(WIDE_W'(num_s3[k]) - WIDE_W'(q0_s3[k]) * WIDE_W'(UNIT));
			res_s5[k] <= (qfix[k] > QUO_W'(UNIT)) ? LANE_W'(UNIT) : qfix[k][LANE_W-1:0];
		end
	end

	assign done   = vld_q[4];
	assign result = res_s5;

endmodule

`default_nettype wire

[hdl/cso_resolve.sv]
// Resolve unit: alpha byte by reciprocal multiply, colour bytes by a nine-step divider.
// Depends on cso_pkg for the accumulator and channel types.
`default_nettype none

module cso_resolve import cso_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire accum_t                 word,
	output logic                        done,
	output channel_t [NUM_COLOURS-1:0] colour,
	output channel_t                    alpha
);

	localparam int unsigned QUO_W   = CH_W + 1;
	localparam int unsigned STEP_W  = $clog2(QUO_W);
	localparam int unsigned DIV_W   = LANE_W + CH_W + 1;   // 2A shifted up by CH_W
	localparam int unsigned NUM_W   = DIV_W + 1;           // 510 * d + A
	localparam int unsigned ARND_W  = LANE_W + 1;
	localparam int unsigned RCP_W   = 18;
	localparam int unsigned RCP_SH  = 25;
	localparam int unsigned APROD_W = ARND_W + RCP_W;
	localparam int unsigned ABYTE_W = APROD_W - RCP_SH;
	// ceil(2^25 / 255), exact for every dividend up to 65662, the largest that a_rnd can take.
	localparam logic [RCP_W-1:0] RCP255 = RCP_W'(((64'd1 << RCP_SH) + 64'd254) / 64'd255);
	localparam int unsigned ALPHA_RND = 127;

	lane_t                            a_in;
	logic [ARND_W-1:0]                a_rnd;
	logic [APROD_W-1:0]               a_prod;
	logic [ABYTE_W-1:0]               a_byte;
	logic [NUM_COLOURS-1:0]           ge;
	logic [NUM_COLOURS-1:0][NUM_W-1:0] rem_q;
	logic [NUM_COLOURS-1:0][QUO_W-1:0] quo_q;
	logic [DIV_W-1:0]                 div_q;
	channel_t                         alpha_q;
	logic                             a_zero_q;
	logic                             busy_q;
	logic                             done_q;
	logic [STEP_W-1:0]                step_q;

	assign a_in   = word[ALPHA_LANE];
	assign a_rnd  = ARND_W'(a_in) + ARND_W'(ALPHA_RND);
	assign a_prod = APROD_W'(a_rnd) * APROD_W'(RCP255);
	assign a_byte = a_prod[APROD_W-1:RCP_SH];

	always_comb begin
		for (int k = 0; k < NUM_COLOURS; k++) begin
			ge[k] = rem_q[k] >= NUM_W'(div_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q && (step_q == '0)) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// Restoring division of 510*d + A by 2A; the top quotient bit means saturation.
	always_ff @(posedge clk) begin
		if (start) begin
			alpha_q  <= (a_byte > ABYTE_W'(255)) ? '1 : a_byte[CH_W-1:0];
			a_zero_q <= (a_in == '0);
			div_q    <= {a_in, (CH_W + 1)'(0)};
			for (int k = 0; k < NUM_COLOURS; k++) begin
				rem_q[k] <= NUM_W'({word[k], 9'd0}) - NUM_W'({word[k], 1'b0}) + NUM_W'(a_in);
				quo_q[k] <= '0;
			end
		end else if (busy_q) begin
			div_q <= div_q >> 1;
			for (int k = 0; k < NUM_COLOURS; k++) begin
				if (ge[k]) begin
					rem_q[k] <= rem_q[k] - NUM_W'(div_q);
				end
				quo_q[k] <= {quo_q[k][QUO_W-2:0], ge[k]};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_COLOURS; k++) begin
			if (a_zero_q) begin
				colour[k] = '0;
			end else if (quo_q[k][QUO_W-1]) begin
				colour[k] = '1;
			end else begin
				colour[k] = quo_q[k][CH_W-1:0];
			end
		end
	end

	assign alpha = alpha_q;
	assign done  = done_q;

endmodule

`default_nettype wire

[hdl/coverage_source_over_compositor_unit.sv]
// Source-over compositor top level: sequencer, accumulator store, blend and resolve units.
// A blend passes EXEC and BLEND and writes back; one that leaves the pixel alone ends in EXEC.
// A resolve passes EXEC, RESOLVE and PUSH; the block is idle again once its result is loaded.
// The rate is set by the five-stage blend pipeline and the nine-step resolve divider.
// After reset the store is swept clear, one entry a cycle, through all TILE_SIDE*TILE_SIDE entries;
// in_ready stays low for the whole sweep.
`default_nettype none

module coverage_source_over_compositor_unit import cso_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             op,
	input  wire logic [IDX_W-1:0] pixel_index,
	input  wire channel_t         coverage,
	input  wire channel_t         src_red,
	input  wire channel_t         src_green,
	input  wire channel_t         src_blue,
	input  wire channel_t         src_alpha,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [IDX_W-1:0]      out_index,
	output channel_t              out_red,
	output channel_t              out_green,
	output channel_t              out_blue,
	output channel_t              out_alpha
);

	// The sequencer takes one item at a time. EXEC is the cycle in which the
	// store's read data for the item is available; from there a blend runs
	// through the blend pipeline and writes back, while a resolve clears the
	// entry at once and waits for the divider before pushing its result.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_BLEND,
		ST_RESOLVE,
		ST_PUSH
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

	state_t                        state_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	op_t                           op_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          inside_q;
	lane_t                         sa_q;
	lane_t                         inv_q;
	channel_t [NUM_COLOURS-1:0]    colour_q;
	logic                          out_valid_q;
	logic [IDX_W-1:0]              out_index_q;
	channel_t [NUM_COLOURS-1:0]    out_colour_q;
	channel_t                      out_alpha_q;

	logic                          accept;
	lane_t                         sa_in;
	logic                          inside_in;
	logic [ADDR_W-1:0]             item_addr;
	logic                          blend_start;
	logic                          res_start;
	logic                          out_load;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	accum_t                        wr_data;
	accum_t                        rd_data;
	accum_t                        res_word;
	logic                          blend_done;
	accum_t                        blend_result;
	logic                          res_done;
	channel_t [NUM_COLOURS-1:0]    res_colour;
	channel_t                      res_alpha;

	// A transfer is taken only in IDLE; the store read is issued in the same
	// cycle so that the entry is ready in EXEC.
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign sa_in     = LANE_W'(src_alpha) * LANE_W'(coverage);
	assign inside_in = 32'(pixel_index) < 32'(PIXELS);
	assign item_addr = ADDR_W'(idx_q);

	// A blend with zero source alpha, or one that falls outside the tile,
	// leaves the store untouched and costs nothing beyond EXEC.
	assign blend_start = (state_q == ST_EXEC) && (op_q == OP_BLEND) && inside_q
		&& (sa_q != '0);
	assign res_start   = (state_q == ST_EXEC) && (op_q == OP_RESOLVE);

	// A resolve outside the tile sees an empty pixel, which yields all-zero bytes.
	assign res_word = inside_q ? rd_data : '0;

	// The output register is loaded when it is empty or being emptied in the
	// same cycle, so one result may wait there while the next item is taken.
	assign out_load = (state_q == ST_PUSH) && (!out_valid_q || out_ready);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = item_addr;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
			end
			ST_EXEC: begin
				wr_en = res_start && inside_q;
			end
			ST_BLEND: begin
				wr_en   = blend_done;
				wr_data = blend_result;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			op_q         <= OP_BLEND;
			idx_q        <= '0;
			inside_q     <= 1'b0;
			sa_q         <= '0;
			inv_q        <= '0;
			colour_q     <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_colour_q <= '0;
			out_alpha_q  <= '0;
		end else begin
			if (accept) begin
				op_q     <= op_t'(op);
				idx_q    <= pixel_index;
				inside_q <= inside_in;
				sa_q     <= sa_in;
				inv_q    <= LANE_W'(UNIT) - sa_in;
				colour_q <= {src_blue, src_green, src_red};
			end

			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_index_q  <= idx_q;
				out_colour_q <= res_colour;
				out_alpha_q  <= res_alpha;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (res_start) begin
						state_q <= ST_RESOLVE;
					end else if (blend_start) begin
						state_q <= ST_BLEND;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BLEND: begin
					if (blend_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESOLVE: begin
					if (res_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	cso_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(pixel_index)),
		.rd_data (rd_data)
	);

	cso_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.sa     (sa_q),
		.inv    (inv_q),
		.colour (colour_q),
		.word   (rd_data),
		.done   (blend_done),
		.result (blend_result)
	);

	cso_resolve u_resolve (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (res_start),
		.word   (res_word),
		.done   (res_done),
		.colour (res_colour),
		.alpha  (res_alpha)
	);

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_red   = out_colour_q[0];
	assign out_green = out_colour_q[1];
	assign out_blue  = out_colour_q[2];
	assign out_alpha = out_alpha_q;

endmodule

`default_nettype wire

[hdl/cso_checker.sv]
// Port-level checker for the compositor top level, bound to it below.
// Depends only on the top level's ports.
`default_nettype none

module cso_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        op,
	input wire logic [15:0] pixel_index,
	input wire logic [7:0]  coverage,
	input wire logic [7:0]  src_red,
	input wire logic [7:0]  src_green,
	input wire logic [7:0]  src_blue,
	input wire logic [7:0]  src_alpha,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_index,
	input wire logic [7:0]  out_red,
	input wire logic [7:0]  out_green,
	input wire logic [7:0]  out_blue,
	input wire logic [7:0]  out_alpha
);

	// A result that is not taken stays presented.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_index) && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue) && $stable(out_alpha))
		else $error("result payload changed while stalled");

	// Items are taken one at a time: no transfer in the cycle after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	// A resolve needs the divider, so no result appears right after a transfer.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised directly after an input transfer");

endmodule

bind coverage_source_over_compositor_unit cso_checker u_cso_checker (.*);

`default_nettype wire
